[rtl/fbac_pkg.sv]
// Shared types, constants and control structs of the framebuffer alpha compositor.
package fbac_pkg;

    // Field and datapath widths
    localparam int unsigned DIM_W      = 9;   // frame width and height registers
    localparam int unsigned POS_W      = 8;   // pixel coordinates and offsets
    localparam int unsigned CH_W       = 8;   // one color channel
    localparam int unsigned PIX_W      = 32;  // packed RGBA word, red in the low byte
    localparam int unsigned LANES      = 3;   // red, green, blue
    localparam int unsigned PROD_W     = 18;  // width times height, width times row
    localparam int unsigned NUM_W      = 17;  // blend numerator per channel
    localparam int unsigned DIV_STEPS  = 8;   // quotient bits of the alpha divider
    localparam int unsigned DIV_CNT_W  = 3;

    // Frame store geometry defaults
    localparam int unsigned DEF_MAX_WIDTH  = 256;
    localparam int unsigned DEF_MAX_HEIGHT = 256;

    // Divide by 255 for 16-bit values: (v * 0x8081) >> 23
    localparam logic [15:0] RECIP_255   = 16'h8081;
    localparam int unsigned RECIP_SHIFT = 23;
    localparam logic [7:0]  CH_MAX      = 8'd255;

    // APB register map
    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_OFFSET_X     = 2'd2;
    localparam logic [1:0] REG_OFFSET_Y     = 2'd3;

    localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = 9'd256;
    localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = 9'd256;
    localparam logic [POS_W-1:0] RST_OFFSET_X     = 8'd0;
    localparam logic [POS_W-1:0] RST_OFFSET_Y     = 8'd0;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_BLEND = 2'd2,
        ACT_FILL  = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_WR,
        ST_RD,
        ST_FILL,
        ST_BL_PROD,
        ST_BL_RECIP,
        ST_BL_REM,
        ST_BL_LANE,
        ST_BL_Q255,
        ST_BL_SUM,
        ST_DIV,
        ST_WB,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [DIM_W-1:0] frame_width;
        logic [DIM_W-1:0] frame_height;
        logic [POS_W-1:0] offset_x;
        logic [POS_W-1:0] offset_y;
    } cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic latch;      // capture the input beat
        logic decode;     // bounds, address, fill length
        logic mem_rd;     // registered frame store read
        logic wr_item;    // store the input pixel if in bounds
        logic fill_step;  // store the fill pixel at the fill counter
        logic bl_prod;
        logic bl_recip;
        logic bl_rem;
        logic bl_lane;
        logic bl_q255;
        logic bl_sum;
        logic div_step;
        logic wr_blend;   // write back the blend result
        logic out_load;   // move the result into the output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        action_t act;
        logic    inb;
        logic    fill_done;
        logic    div_last;
        logic    out_free;
    } sts_t;

endpackage

[rtl/fbac_ifs.sv]
// Valid/ready channel interfaces for pixel requests and results.
interface fbac_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] x_pos;
    logic [7:0] y_pos;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;

    modport source (
        output valid, action, x_pos, y_pos, red_in, green_in, blue_in, alpha_in,
        input  ready
    );
    modport sink (
        input  valid, action, x_pos, y_pos, red_in, green_in, blue_in, alpha_in,
        output ready
    );
endinterface

interface fbac_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       in_bounds;

    modport source (
        output valid, red_out, green_out, blue_out, alpha_out, in_bounds,
        input  ready
    );
    modport sink (
        input  valid, red_out, green_out, blue_out, alpha_out, in_bounds,
        output ready
    );
endinterface

[rtl/framebuffer_alpha_compositor_top.sv]
// Top level of the RGBA8 framebuffer alpha compositor.
// The block keeps a MAX_WIDTH x MAX_HEIGHT frame of RGBA8 pixels in a simple dual-port
// memory (one write port and one registered read port) and handles one request beat
// at a time, returning exactly one result beat per request. Pixel (x,y) sits at
// address frame_width*y + x. The sequencer takes a new request only after the result
// of the previous one has been loaded into the output register. Blend time is set by
// the fixed six-step arithmetic pipeline (the two divides by 255 use reciprocal
// multiplies) and by the per-lane restoring dividers, which share one divisor register
// and produce one quotient bit per cycle for the division by the output alpha; fill
// time is set by the memory write port, one pixel per cycle. A result sits in an
// output register, so a new request is taken while the previous result waits. Pixels
// never written read as undefined. Registers (APB, 4-byte stride): frame_width,
// frame_height, offset_x, offset_y; write them only while the block is idle.
module framebuffer_alpha_compositor_top #(
    parameter int unsigned MAX_WIDTH  = fbac_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = fbac_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fbac_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [fbac_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [fbac_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    fbac_req_if.sink                          req,
    fbac_rsp_if.source                        rsp
);
    import fbac_pkg::*;

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;
    logic in_ready;

    fbac_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fbac_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fbac_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .cmd           (cmd),
        .sts           (sts),
        .in_action     (req.action),
        .in_x_pos      (req.x_pos),
        .in_y_pos      (req.y_pos),
        .in_red        (req.red_in),
        .in_green      (req.green_in),
        .in_blue       (req.blue_in),
        .in_alpha      (req.alpha_in),
        .out_valid     (rsp.valid),
        .out_ready     (rsp.ready),
        .out_red       (rsp.red_out),
        .out_green     (rsp.green_out),
        .out_blue      (rsp.blue_out),
        .out_alpha     (rsp.alpha_out),
        .out_in_bounds (rsp.in_bounds)
    );

    assign req.ready = in_ready;

endmodule

[rtl/fbac_cfg.sv]
// APB register file holding frame size and blend offsets.
module fbac_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fbac_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [fbac_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [fbac_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output fbac_pkg::cfg_t                      cfg
);
    import fbac_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite & pready;

    // Register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_FRAME_WIDTH:  cfg_next.frame_width  = pwdata[DIM_W-1:0];
                REG_FRAME_HEIGHT: cfg_next.frame_height = pwdata[DIM_W-1:0];
                REG_OFFSET_X:     cfg_next.offset_x     = pwdata[POS_W-1:0];
                REG_OFFSET_Y:     cfg_next.offset_y     = pwdata[POS_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width  <= RST_FRAME_WIDTH;
            cfg_reg.frame_height <= RST_FRAME_HEIGHT;
            cfg_reg.offset_x     <= RST_OFFSET_X;
            cfg_reg.offset_y     <= RST_OFFSET_Y;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read mux
    always_comb
    begin
        case (reg_idx)
            REG_FRAME_WIDTH:  prdata = APB_DATA_W'(cfg_reg.frame_width);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(cfg_reg.frame_height);
            REG_OFFSET_X:     prdata = APB_DATA_W'(cfg_reg.offset_x);
            REG_OFFSET_Y:     prdata = APB_DATA_W'(cfg_reg.offset_y);
            default:          prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

[rtl/fbac_ctrl.sv]
// Sequencer that steps the datapath through write, read, fill and blend.
module fbac_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  fbac_pkg::sts_t  sts,
    output fbac_pkg::cmd_t  cmd
);
    import fbac_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_DECODE;
            end
            ST_DECODE:
            begin
                case (sts.act)
                    ACT_WRITE: state_next = ST_WR;
                    ACT_READ:  state_next = ST_RD;
                    ACT_BLEND: state_next = ST_RD;
                    ACT_FILL:  state_next = ST_FILL;
                    default:   state_next = ST_OUT;
                endcase
            end
            ST_WR:       state_next = ST_OUT;
            ST_RD:
            begin
                // clipped blends skip the arithmetic
                if (sts.act == ACT_BLEND && sts.inb)
                    state_next = ST_BL_PROD;
                else
                    state_next = ST_OUT;
            end
            ST_FILL:
            begin
                if (sts.fill_done)
                    state_next = ST_OUT;
            end
            ST_BL_PROD:  state_next = ST_BL_RECIP;
            ST_BL_RECIP: state_next = ST_BL_REM;
            ST_BL_REM:   state_next = ST_BL_LANE;
            ST_BL_LANE:  state_next = ST_BL_Q255;
            ST_BL_Q255:  state_next = ST_BL_SUM;
            ST_BL_SUM:   state_next = ST_DIV;
            ST_DIV:
            begin
                if (sts.div_last)
                    state_next = ST_WB;
            end
            ST_WB:       state_next = ST_OUT;
            ST_OUT:
            begin
                if (sts.out_free)
                    state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Commands
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.latch = in_valid;
            end
            ST_DECODE:   cmd.decode    = 1'b1;
            ST_WR:       cmd.wr_item   = 1'b1;
            ST_RD:       cmd.mem_rd    = 1'b1;
            ST_FILL:     cmd.fill_step = ~sts.fill_done;
            ST_BL_PROD:  cmd.bl_prod   = 1'b1;
            ST_BL_RECIP: cmd.bl_recip  = 1'b1;
            ST_BL_REM:   cmd.bl_rem    = 1'b1;
            ST_BL_LANE:  cmd.bl_lane   = 1'b1;
            ST_BL_Q255:  cmd.bl_q255   = 1'b1;
            ST_BL_SUM:   cmd.bl_sum    = 1'b1;
            ST_DIV:      cmd.div_step  = 1'b1;
            ST_WB:       cmd.wr_blend  = 1'b1;
            ST_OUT:      cmd.out_load  = sts.out_free;
            default:     cmd           = '0;
        endcase
    end

endmodule

[rtl/fbac_dp.sv]
// Datapath: frame store, address and bounds logic, blend arithmetic, result register.
module fbac_dp #(
    parameter int unsigned MAX_WIDTH  = fbac_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = fbac_pkg::DEF_MAX_HEIGHT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  fbac_pkg::cfg_t               cfg,
    input  fbac_pkg::cmd_t               cmd,
    output fbac_pkg::sts_t               sts,
    input  logic [1:0]                   in_action,
    input  logic [fbac_pkg::POS_W-1:0]   in_x_pos,
    input  logic [fbac_pkg::POS_W-1:0]   in_y_pos,
    input  logic [fbac_pkg::CH_W-1:0]    in_red,
    input  logic [fbac_pkg::CH_W-1:0]    in_green,
    input  logic [fbac_pkg::CH_W-1:0]    in_blue,
    input  logic [fbac_pkg::CH_W-1:0]    in_alpha,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [fbac_pkg::CH_W-1:0]    out_red,
    output logic [fbac_pkg::CH_W-1:0]    out_green,
    output logic [fbac_pkg::CH_W-1:0]    out_blue,
    output logic [fbac_pkg::CH_W-1:0]    out_alpha,
    output logic                         out_in_bounds
);
    import fbac_pkg::*;

    localparam int unsigned DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W  = (ADDR_W > PROD_W) ? ADDR_W : PROD_W;
    localparam int unsigned WCAP   = (MAX_WIDTH  > 511) ? 511 : MAX_WIDTH;
    localparam int unsigned HCAP   = (MAX_HEIGHT > 511) ? 511 : MAX_HEIGHT;
    localparam int unsigned DSH_W  = CH_W + DIV_STEPS - 1;

    // x / 255 for x below 2^16
    function automatic logic [CH_W-1:0] div255(input logic [15:0] v);
        logic [31:0] prod;
        begin
            prod = 32'(v) * 32'(RECIP_255);
            return CH_W'(prod >> RECIP_SHIFT);
        end
    endfunction

    // Frame store
    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] mem_q_reg;
    logic             mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [PIX_W-1:0] mem_wdata;

    // Captured beat
    action_t          act_reg;
    logic [POS_W-1:0] x_reg;
    logic [POS_W-1:0] y_reg;
    logic [PIX_W-1:0] pix_reg;

    // Decode
    logic [DIM_W-1:0]  w_eff;
    logic [DIM_W-1:0]  h_eff;
    logic [DIM_W-1:0]  col;
    logic [DIM_W-1:0]  row;
    logic [PROD_W-1:0] row_base;
    logic [PROD_W-1:0] area;
    logic [CNT_W-1:0]  addr_full;
    logic              inb_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [CNT_W-1:0]  fill_n_reg;
    logic [CNT_W-1:0]  fill_cnt_reg;

    // Blend
    logic [CH_W-1:0]   a1;
    logic [CH_W-1:0]   a2;
    logic [15:0]       p_reg;
    logic [CH_W-1:0]   t_reg;
    logic [CH_W-1:0]   r_reg;
    logic [CH_W-1:0]   aout_reg;
    logic [15:0]       c1a1_reg [LANES];
    logic [15:0]       ct_reg   [LANES];
    logic [15:0]       cr_reg   [LANES];
    logic [CH_W-1:0]   qr_reg   [LANES];
    logic [NUM_W-1:0]  sum_w    [LANES];
    logic [NUM_W-1:0]  rem_reg  [LANES];
    logic              sat_reg  [LANES];
    logic [CH_W-1:0]   q_reg    [LANES];
    logic [CH_W-1:0]   res_c    [LANES];
    logic [DSH_W-1:0]  dsh_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [PIX_W-1:0]  blend_pix;

    // Result
    logic              out_valid_reg;
    logic [PIX_W-1:0]  res_pix;
    logic              res_inb;
    logic [PIX_W-1:0]  out_pix_reg;
    logic              out_inb_reg;

    assign a1 = mem_q_reg[3*CH_W +: CH_W];
    assign a2 = pix_reg[3*CH_W +: CH_W];

    // Bounds and address; blends land at the offset position
    always_comb
    begin
        w_eff = (cfg.frame_width  > DIM_W'(WCAP)) ? DIM_W'(WCAP) : cfg.frame_width;
        h_eff = (cfg.frame_height > DIM_W'(HCAP)) ? DIM_W'(HCAP) : cfg.frame_height;
        if (act_reg == ACT_BLEND)
        begin
            col = DIM_W'(x_reg) + DIM_W'(cfg.offset_x);
            row = DIM_W'(y_reg) + DIM_W'(cfg.offset_y);
        end
        else
        begin
            col = DIM_W'(x_reg);
            row = DIM_W'(y_reg);
        end
        row_base  = PROD_W'(w_eff) * PROD_W'(row);
        area      = PROD_W'(w_eff) * PROD_W'(h_eff);
        addr_full = CNT_W'(row_base) + CNT_W'(col);
    end

    // Frame store write port
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = pix_reg;
        if (cmd.fill_step)
        begin
            mem_we    = 1'b1;
            mem_waddr = fill_cnt_reg[ADDR_W-1:0];
        end
        else if (cmd.wr_item)
        begin
            mem_we = inb_reg;
        end
        else if (cmd.wr_blend)
        begin
            mem_we    = 1'b1;
            mem_wdata = blend_pix;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (cmd.mem_rd)
            mem_q_reg <= mem[addr_reg];
    end

    // Beat capture and decode registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            act_reg <= action_t'(in_action);
            x_reg   <= in_x_pos;
            y_reg   <= in_y_pos;
            pix_reg <= {in_alpha, in_blue, in_green, in_red};
        end
        if (cmd.decode)
        begin
            inb_reg    <= (col < w_eff) && (row < h_eff);
            addr_reg   <= addr_full[ADDR_W-1:0];
            fill_n_reg <= CNT_W'(area);
        end
    end

    // Per-channel numerator terms: c1*a1 + c2*t + floor(c2*r/255)
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
            sum_w[k] = NUM_W'(c1a1_reg[k]) + NUM_W'(ct_reg[k]) + NUM_W'(qr_reg[k]);
    end

    // Blend pipeline steps
    always_ff @(posedge clk)
    begin
        if (cmd.bl_prod)
        begin
            p_reg <= 16'(a2) * 16'(CH_MAX - a1);
            for (int k = 0; k < LANES; k++)
                c1a1_reg[k] <= 16'(mem_q_reg[k*CH_W +: CH_W]) * 16'(a1);
        end
        if (cmd.bl_recip)
            t_reg <= div255(p_reg);
        if (cmd.bl_rem)
        begin
            r_reg    <= CH_W'(p_reg - ((16'(t_reg) << CH_W) - 16'(t_reg)));
            aout_reg <= a1 + t_reg;
        end
        if (cmd.bl_lane)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                ct_reg[k] <= 16'(pix_reg[k*CH_W +: CH_W]) * 16'(t_reg);
                cr_reg[k] <= 16'(pix_reg[k*CH_W +: CH_W]) * 16'(r_reg);
            end
        end
        if (cmd.bl_q255)
        begin
            for (int k = 0; k < LANES; k++)
                qr_reg[k] <= div255(cr_reg[k]);
        end
        // load dividers; a numerator at or above 256*aout saturates
        if (cmd.bl_sum)
        begin
            dsh_reg <= {aout_reg, {(DIV_STEPS-1){1'b0}}};
            for (int k = 0; k < LANES; k++)
            begin
                rem_reg[k] <= sum_w[k];
                sat_reg[k] <= sum_w[k] >= {1'b0, aout_reg, {CH_W{1'b0}}};
                q_reg[k]   <= '0;
            end
        end
        // restoring division, one quotient bit per lane per cycle
        if (cmd.div_step)
        begin
            dsh_reg <= dsh_reg >> 1;
            for (int k = 0; k < LANES; k++)
            begin
                if (rem_reg[k] >= NUM_W'(dsh_reg))
                begin
                    rem_reg[k] <= rem_reg[k] - NUM_W'(dsh_reg);
                    q_reg[k]   <= {q_reg[k][CH_W-2:0], 1'b1};
                end
                else
                begin
                    q_reg[k] <= {q_reg[k][CH_W-2:0], 1'b0};
                end
            end
        end
    end

    // Blend result word
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            if (aout_reg == '0)
                res_c[k] = '0;
            else if (sat_reg[k])
                res_c[k] = CH_MAX;
            else
                res_c[k] = q_reg[k];
        end
        blend_pix = {aout_reg, res_c[2], res_c[1], res_c[0]};
    end

    // Control counters and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_cnt_reg  <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.decode)
                fill_cnt_reg <= '0;
            else if (cmd.fill_step)
                fill_cnt_reg <= fill_cnt_reg + 1'b1;

            if (cmd.bl_sum)
                div_cnt_reg <= '0;
            else if (cmd.div_step)
                div_cnt_reg <= div_cnt_reg + 1'b1;

            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Result selection per action
    always_comb
    begin
        res_pix = '0;
        res_inb = 1'b0;
        case (act_reg)
            ACT_WRITE:
            begin
                res_inb = inb_reg;
            end
            ACT_READ:
            begin
                res_inb = inb_reg;
                res_pix = inb_reg ? mem_q_reg : {CH_MAX, {(3*CH_W){1'b0}}};
            end
            ACT_BLEND:
            begin
                res_inb = inb_reg;
                res_pix = inb_reg ? blend_pix : '0;
            end
            ACT_FILL:
            begin
                res_inb = 1'b0;
            end
            default:
            begin
                res_pix = '0;
                res_inb = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_pix_reg <= res_pix;
            out_inb_reg <= res_inb;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_red       = out_pix_reg[0*CH_W +: CH_W];
    assign out_green     = out_pix_reg[1*CH_W +: CH_W];
    assign out_blue      = out_pix_reg[2*CH_W +: CH_W];
    assign out_alpha     = out_pix_reg[3*CH_W +: CH_W];
    assign out_in_bounds = out_inb_reg;

    // Status to the sequencer
    assign sts.act       = act_reg;
    assign sts.inb       = inb_reg;
    assign sts.fill_done = (fill_cnt_reg == fill_n_reg);
    assign sts.div_last  = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign sts.out_free  = ~out_valid_reg | out_ready;

endmodule
